// ===== hdl/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted region table
// Transfer payloads, the table entry, cell control and flag groups, the
// selection result, operation and status codes and the controller states.
// ----------------------------------------------------------------------------
package srt_pkg;

  // field widths
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STATUS_W    = 2;

  // default table depth
  localparam int unsigned ENTRIES_DEF = 64;

  // configuration port
  localparam int unsigned PADDR_W        = 2;
  localparam int unsigned PDATA_W        = 32;
  localparam logic [PADDR_W-1:0] REG_PAGE_SHIFT = 2'd0;
  localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_e;

  // input transfer
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] region_size;
    logic [TAG_W-1:0]  region_tag;
  } req_t;

  // output transfer
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [TAG_W-1:0]       hit_tag;
    logic [ADDR_W-1:0]      offset;
    logic [ADDR_W-1:0]      page_address;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic cap;  // capture compare flags against the incoming address
    logic ins;  // open a gap and insert
    logic rem;  // close the gap over the matching entry
  } cell_ctrl_t;

  // compare flags held in each cell
  typedef struct packed {
    logic lt;   // entry valid and base below address
    logic eq;   // entry valid and base equal to address
    logic inr;  // address below base plus size
  } cell_flags_t;

  // outcome of the selection network
  typedef struct packed {
    logic              match;  // some valid base equals the address
    logic              hit;    // chosen region covers the address
    logic [ADDR_W-1:0] base;
    logic [TAG_W-1:0]  tag;
  } pick_t;

endpackage

// ===== hdl/srt_cell.sv =====
// ----------------------------------------------------------------------------
// srt_cell: one slot of the sorted region chain
// Holds one region, compares it against the incoming address and shifts
// towards either neighbour on insert or remove.
// ----------------------------------------------------------------------------
module srt_cell import srt_pkg::*; (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  entry_t            new_i,
  input  logic              valid_i,
  input  logic              prev_valid_i,
  input  logic              prev_lt_i,
  input  entry_t            prev_i,
  input  entry_t            next_i,
  output entry_t            ent_o,
  output cell_flags_t       flags_o,
  output logic              head_o
);

  entry_t            ent_q;
  cell_flags_t       flags_q;
  cell_flags_t       flags_d;
  logic [ADDR_W:0]   end_addr;

  // compare against the address of the incoming transfer
  always_comb begin
    end_addr   = {1'b0, ent_q.base} + {1'b0, ent_q.size};
    flags_d.lt  = valid_i && (ent_q.base < addr_i);
    flags_d.eq  = valid_i && (ent_q.base == addr_i);
    flags_d.inr = ({1'b0, addr_i} < end_addr);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      flags_q <= flags_d;
    end
  end

  // entries below the address stay, the rest shift by one place
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !flags_q.lt) begin
      ent_q <= prev_lt_i ? new_i : prev_i;
    end else if (ctrl_i.rem && !flags_q.lt) begin
      ent_q <= next_i;
    end
  end

  // first entry of a run of equal bases
  assign head_o  = !prev_valid_i || (ent_q.base != prev_i.base);
  assign ent_o   = ent_q;
  assign flags_o = flags_q;

endmodule

// ===== hdl/srt_sel.sv =====
// ----------------------------------------------------------------------------
// srt_sel: lookup selection network
// Finds the first entry of the highest base not above the address with a
// log-depth scan along the chain, then gathers its fields.
// ----------------------------------------------------------------------------
module srt_sel import srt_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic [ENTRIES-1:0] valid_i,
  input  logic [ENTRIES-1:0] head_i,
  input  logic [ENTRIES-1:0] lt_i,
  input  logic [ENTRIES-1:0] eq_i,
  input  logic [ENTRIES-1:0] inr_i,
  input  entry_t             ent_i [ENTRIES],
  output pick_t              pick_o
);

  localparam int unsigned LVLS = $clog2(ENTRIES);

  logic [ENTRIES-1:0] le;
  logic [ENTRIES-1:0] sel;
  logic [ENTRIES-1:0] g [LVLS+1];
  logic [ENTRIES-1:0] p [LVLS+1];

  assign le = lt_i | eq_i;

  // generate at the last entry not above the address, propagate through
  // equal neighbours back to the head of the run
  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_seed
    if (gi < ENTRIES - 1) begin : g_mid
      assign g[0][gi] = le[gi] && !le[gi+1];
      assign p[0][gi] = valid_i[gi+1] && !head_i[gi+1];
    end else begin : g_end
      assign g[0][gi] = le[gi];
      assign p[0][gi] = 1'b0;
    end
  end

  // backward prefix scan
  for (genvar gl = 0; gl < LVLS; gl++) begin : g_lvl
    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_bit
      if (gi + (1 << gl) < ENTRIES) begin : g_comb
        assign g[gl+1][gi] = g[gl][gi] | (p[gl][gi] & g[gl][gi + (1 << gl)]);
        assign p[gl+1][gi] = p[gl][gi] & p[gl][gi + (1 << gl)];
      end else begin : g_pass
        assign g[gl+1][gi] = g[gl][gi];
        assign p[gl+1][gi] = 1'b0;
      end
    end
  end

  assign sel = g[LVLS] & head_i & le;

  // gather the chosen entry
  always_comb begin
    pick_o.match = |eq_i;
    pick_o.hit   = |(sel & inr_i);
    pick_o.base  = '0;
    pick_o.tag   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        pick_o.base = pick_o.base | ent_i[i].base;
        pick_o.tag  = pick_o.tag | ent_i[i].tag;
      end
    end
  end

endmodule

// ===== hdl/sorted_region_table_lookup_core.sv =====
// ----------------------------------------------------------------------------
// sorted_region_table_lookup_core: sorted address region table
// Keeps regions in a chain of cells ordered by base and answers insert,
// remove and lookup requests, one result transfer per request transfer.
//
// Use:
//   in channel  (in_valid_i / in_ready_o / in_data_i): one request per
//     transfer: insert a region, remove a region by base, or look up an
//     address.
//   out channel (out_valid_o / out_ready_i / out_data_o): one result per
//     request, in request order, held in an output register until taken.
//   APB port: page_shift at byte address 0; the user must write it only while
//     idle, which the block itself does not enforce.
//   Timing: a request is compared against the chain as it is taken; the chain
//     shifts or the selection scan runs in the execute state; the result is
//     registered in the finish state, where the next request can be taken.
//   Stall: a waiting result does not block the next request; that request
//     holds in its final cycle until the output register is free.
//   Reset: the table is empty and page_shift is 12; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_region_table_lookup_core import srt_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsp_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  state_e             state_q, state_d;
  req_t               req_q;
  logic [CW-1:0]      count_q, count_d;
  logic [SHIFT_W-1:0] page_shift_q;
  status_e            res_status_q, res_status_d;
  logic               res_hit_q;
  logic [ADDR_W-1:0]  res_base_q;
  logic [TAG_W-1:0]   res_tag_q;
  logic               out_valid_q;
  rsp_t               out_data_q, out_data_d;

  logic               out_free;
  logic               accept;
  logic               full;
  logic               finish_go;
  cell_ctrl_t         ctrl;
  pick_t              pick;
  entry_t             new_ent;
  logic [ADDR_W-1:0]  page_mask;

  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] head;
  logic [ENTRIES-1:0] lt_v;
  logic [ENTRIES-1:0] eq_v;
  logic [ENTRIES-1:0] inr_v;
  entry_t             ent [ENTRIES];
  cell_flags_t        flags [ENTRIES];

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PAGE_SHIFT) ? PDATA_W'(page_shift_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= PAGE_SHIFT_RST;
    end else if (psel && penable && pwrite && pready && (paddr == REG_PAGE_SHIFT)) begin
      page_shift_q <= pwdata[SHIFT_W-1:0];
    end
  end

  // chain of cells
  assign new_ent.base = req_q.address;
  assign new_ent.size = req_q.region_size;
  assign new_ent.tag  = req_q.region_tag;

  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_valid;
    logic   prev_lt;

    assign valid[gi] = count_q > CW'(gi);

    if (gi == 0) begin : g_first
      assign prev_ent   = '0;
      assign prev_valid = 1'b0;
      assign prev_lt    = 1'b1;
    end else begin : g_rest
      assign prev_ent   = ent[gi-1];
      assign prev_valid = valid[gi-1];
      assign prev_lt    = lt_v[gi-1];
    end

    if (gi == ENTRIES - 1) begin : g_last
      assign next_ent = ent[gi];
    end else begin : g_inner
      assign next_ent = ent[gi+1];
    end

    srt_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .addr_i       (in_data_i.address),
      .new_i        (new_ent),
      .valid_i      (valid[gi]),
      .prev_valid_i (prev_valid),
      .prev_lt_i    (prev_lt),
      .prev_i       (prev_ent),
      .next_i       (next_ent),
      .ent_o        (ent[gi]),
      .flags_o      (flags[gi]),
      .head_o       (head[gi])
    );

    assign lt_v[gi]  = flags[gi].lt;
    assign eq_v[gi]  = flags[gi].eq;
    assign inr_v[gi] = flags[gi].inr;
  end

  // lookup selection
  srt_sel #(
    .ENTRIES (ENTRIES)
  ) u_sel (
    .valid_i (valid),
    .head_i  (head),
    .lt_i    (lt_v),
    .eq_i    (eq_v),
    .inr_i   (inr_v),
    .ent_i   (ent),
    .pick_o  (pick)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_d = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // controller outputs
  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == S_IDLE) || ((state_q == S_FINISH) && out_free);
    accept     = in_valid_i && in_ready_o;
    full       = count_q == CW'(ENTRIES);
    ctrl.cap   = accept;
    ctrl.ins   = (state_q == S_EXEC) && (req_q.func == FN_INSERT) && !full;
    ctrl.rem   = (state_q == S_EXEC) && (req_q.func == FN_REMOVE) && pick.match;
    finish_go  = (state_q == S_FINISH) && out_free;
  end

  // fill count
  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = CW'(count_q + 1'b1);
    end else if (ctrl.rem) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  // status of the executed operation
  always_comb begin
    case (func_e'(req_q.func))
      FN_INSERT: res_status_d = full ? STAT_FULL : STAT_OK;
      FN_REMOVE: res_status_d = pick.match ? STAT_OK : STAT_MISS;
      FN_LOOKUP: res_status_d = pick.hit ? STAT_OK : STAT_MISS;
      default:   res_status_d = STAT_OK;
    endcase
  end

  // result transfer fields
  always_comb begin
    page_mask               = {ADDR_W{1'b1}} << page_shift_q;
    out_data_d.status       = res_status_q;
    out_data_d.hit_tag      = '0;
    out_data_d.offset       = '0;
    out_data_d.page_address = '0;
    out_data_d.entry_count  = COUNT_OUT_W'(count_q);
    if (req_q.func == FN_LOOKUP) begin
      out_data_d.page_address = req_q.address & page_mask;
      if (res_hit_q) begin
        out_data_d.hit_tag = res_tag_q;
        out_data_d.offset  = req_q.address - res_base_q;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (finish_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (state_q == S_EXEC) begin
      res_status_q <= res_status_d;
      res_hit_q    <= pick.hit;
      res_base_q   <= pick.base;
      res_tag_q    <= pick.tag;
    end
    if (finish_go) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // the fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("fill count above table depth");

  // an accepted insert grows the table by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> (count_q == CW'($past(count_q) + 1'b1)))
    else $error("insert did not grow the table");

  // execution always hands over to the finishing cycle
  a_exec_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |=> (state_q == S_FINISH))
    else $error("execute cycle not followed by finish");

  // a lookup hit needs a non-empty table
  a_hit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EXEC) && (req_q.func == FN_LOOKUP) && pick.hit) |-> (count_q != '0))
    else $error("lookup hit in an empty table");

endmodule
